// File: rtl/fmas_pkg.sv
// fmas_pkg: shared types, constants and pipeline-step functions of the float
// multiply-add stream. Unpacking, normalization and rounding used by fmas_mul
// and fmas_add. No dependencies.
package fmas_pkg;

   localparam int MUL_STAGES = 6;
   localparam int ADD_STAGES = 8;
   localparam int NUM_STAGES = MUL_STAGES + ADD_STAGES;

   localparam logic signed [13:0] DBL_BIAS = 14'sd1023;
   localparam logic signed [13:0] SGL_BIAS = 14'sd127;
   localparam logic signed [13:0] DBL_EMIN = -14'sd1022;
   localparam logic signed [13:0] SGL_EMIN = -14'sd126;
   localparam logic signed [13:0] DBL_EMAX = 14'sd1023;
   localparam logic signed [13:0] SGL_EMAX = 14'sd127;
   localparam logic signed [13:0] ZERO_EXP = -14'sd3000;

   localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] SGL_QNAN = 64'h0000_0000_7FC0_0000;

   // value = man * 2^(exp-52), man[52] weighs 2^exp
   typedef struct packed {
      logic                sgn;
      logic signed [13:0]  exp;
      logic [52:0]         man;
      logic                zero;
      logic                inf;
      logic                nan;
   } unp_type;

   // frac[127] weighs 2^exp
   typedef struct packed {
      logic                sgn;
      logic signed [13:0]  exp;
      logic [127:0]        frac;
   } nrm_type;

   typedef struct packed {
      logic                sgn;
      logic signed [13:0]  exp;
      logic [52:0]         m;
      logic                g;
      logic                st;
   } rnd_type;

   typedef struct packed {
      logic inf;
      logic nan;
      logic sgn;
   } spc_type;

   function automatic unp_type fp_unpack(input logic [63:0] x, input logic dbl);
      unp_type     u;
      logic [10:0] e;
      logic [51:0] f;
      logic        ones;
      if (dbl) begin
         e = x[62:52];
         f = x[51:0];
         u.sgn = x[63];
         ones = &x[62:52];
      end else begin
         e = {3'b000, x[30:23]};
         f = {x[22:0], 29'b0};
         u.sgn = x[31];
         ones = &x[30:23];
      end
      u.man = {e != 11'd0, f};
      if (e != 11'd0) begin
         u.exp = $signed({3'b000, e}) - (dbl ? DBL_BIAS : SGL_BIAS);
      end else begin
         u.exp = dbl ? DBL_EMIN : SGL_EMIN;
      end
      u.zero = (e == 11'd0) && (f == 52'd0);
      u.inf  = ones && (f == 52'd0);
      u.nan  = ones && (f != 52'd0);
      return u;
   endfunction

   // coarse half of the leading-zero shift
   function automatic nrm_type norm_hi(input nrm_type x);
      nrm_type y;
      y = x;
      if (y.frac[127:64] == 64'd0) begin
         y.frac = y.frac << 64;
         y.exp = y.exp - 14'sd64;
      end
      if (y.frac[127:96] == 32'd0) begin
         y.frac = y.frac << 32;
         y.exp = y.exp - 14'sd32;
      end
      if (y.frac[127:112] == 16'd0) begin
         y.frac = y.frac << 16;
         y.exp = y.exp - 14'sd16;
      end
      if (y.frac[127:120] == 8'd0) begin
         y.frac = y.frac << 8;
         y.exp = y.exp - 14'sd8;
      end
      return y;
   endfunction

   // fine half of the leading-zero shift
   function automatic nrm_type norm_lo(input nrm_type x);
      nrm_type y;
      y = x;
      if (y.frac[127:124] == 4'd0) begin
         y.frac = y.frac << 4;
         y.exp = y.exp - 14'sd4;
      end
      if (y.frac[127:126] == 2'd0) begin
         y.frac = y.frac << 2;
         y.exp = y.exp - 14'sd2;
      end
      if (!y.frac[127]) begin
         y.frac = y.frac << 1;
         y.exp = y.exp - 14'sd1;
      end
      return y;
   endfunction

   // subnormal shift, then split into kept bits, guard and sticky
   function automatic rnd_type rnd_prep(input nrm_type x, input logic dbl);
      rnd_type             r;
      logic signed [14:0]  diff;
      logic [6:0]          sh;
      logic [127:0]        d;
      logic                s0;
      logic signed [13:0]  emin;
      emin = dbl ? DBL_EMIN : SGL_EMIN;
      diff = $signed({emin[13], emin}) - $signed({x.exp[13], x.exp});
      r.sgn = x.sgn;
      if (diff > 15'sd0) begin
         sh = (diff > 15'sd127) ? 7'd127 : diff[6:0];
         d = x.frac >> sh;
         s0 = |(x.frac & ~({128{1'b1}} << sh));
         r.exp = emin;
      end else begin
         sh = 7'd0;
         d = x.frac >> sh;
         s0 = 1'b0;
         r.exp = x.exp;
      end
      if (dbl) begin
         r.m = d[127:75];
         r.g = d[74];
         r.st = (|d[73:0]) | s0;
      end else begin
         r.m = {29'b0, d[127:104]};
         r.g = d[103];
         r.st = (|d[102:0]) | s0;
      end
      return r;
   endfunction

   // round to nearest even, detect overflow
   function automatic unp_type rnd_final(input rnd_type r, input logic dbl);
      unp_type             u;
      logic [53:0]         s;
      logic                inc;
      logic signed [13:0]  e;
      logic signed [13:0]  emax;
      inc = r.g & (r.st | r.m[0]);
      s = {1'b0, r.m} + {53'b0, inc};
      e = r.exp;
      if (dbl) begin
         if (s[53]) begin
            u.man = s[53:1];
            e = e + 14'sd1;
         end else begin
            u.man = s[52:0];
         end
      end else begin
         if (s[24]) begin
            u.man = {s[24:1], 29'b0};
            e = e + 14'sd1;
         end else begin
            u.man = {s[23:0], 29'b0};
         end
      end
      emax = dbl ? DBL_EMAX : SGL_EMAX;
      u.sgn = r.sgn;
      u.exp = e;
      u.zero = (u.man == 53'd0);
      u.inf = (e > emax) && !u.zero;
      u.nan = 1'b0;
      return u;
   endfunction

endpackage

// File: rtl/fmas_mul.sv
// fmas_mul: six-stage rounded multiplier, a*b in single or double precision.
// Uses fmas_pkg for unpacking, normalization and rounding.
module fmas_mul (
   input  logic                          clock,
   input  logic [5:0]                    en,
   input  logic                          dbl,
   input  logic [63:0]                   a,
   input  logic [63:0]                   b,
   output fmas_pkg::unp_type             prod
);
   import fmas_pkg::*;

   unp_type             ua, ub;
   logic [51:0]         hh_in, hh_ff;
   logic [52:0]         hl_in, hl_ff;
   logic [52:0]         lh_in, lh_ff;
   logic [53:0]         ll_in, ll_ff;
   logic                sgn1_in, sgn1_ff;
   logic signed [13:0]  exp1_in, exp1_ff;
   spc_type             spc_in;
   spc_type             spc_ff [4:0];
   logic [105:0]        p106;
   nrm_type             n2_in, n2_ff;
   nrm_type             n3_in, n3_ff;
   nrm_type             n4_in, n4_ff;
   rnd_type             r5_in, r5_ff;
   unp_type             rf;
   unp_type             prod_in, prod_ff;

   always_comb begin
      ua = fp_unpack(a, dbl);
      ub = fp_unpack(b, dbl);
      hh_in = ua.man[52:27] * ub.man[52:27];
      hl_in = ua.man[52:27] * ub.man[26:0];
      lh_in = ua.man[26:0] * ub.man[52:27];
      ll_in = ua.man[26:0] * ub.man[26:0];
      sgn1_in = ua.sgn ^ ub.sgn;
      exp1_in = ua.exp + ub.exp + 14'sd1;
      spc_in.nan = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
      spc_in.inf = (ua.inf | ub.inf) & ~spc_in.nan;
      spc_in.sgn = sgn1_in;
   end

   always_comb begin
      p106 = {hh_ff, 54'b0}
           + {25'b0, ({1'b0, hl_ff} + {1'b0, lh_ff}), 27'b0}
           + {52'b0, ll_ff};
      n2_in.sgn = sgn1_ff;
      n2_in.exp = exp1_ff;
      n2_in.frac = {p106, 22'b0};
      n3_in = norm_hi(n2_ff);
      n4_in = norm_lo(n3_ff);
      r5_in = rnd_prep(n4_ff, dbl);
      rf = rnd_final(r5_ff, dbl);
      prod_in = rf;
      prod_in.inf = rf.inf | spc_ff[4].inf;
      prod_in.nan = spc_ff[4].nan;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
         sgn1_ff <= sgn1_in;
         exp1_ff <= exp1_in;
         spc_ff[0] <= spc_in;
      end
      if (en[1]) begin
         n2_ff <= n2_in;
         spc_ff[1] <= spc_ff[0];
      end
      if (en[2]) begin
         n3_ff <= n3_in;
         spc_ff[2] <= spc_ff[1];
      end
      if (en[3]) begin
         n4_ff <= n4_in;
         spc_ff[3] <= spc_ff[2];
      end
      if (en[4]) begin
         r5_ff <= r5_in;
         spc_ff[4] <= spc_ff[3];
      end
      if (en[5]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: rtl/fmas_add.sv
// fmas_add: eight-stage rounded adder, product + c, with packing and the
// non-finite flag. Uses fmas_pkg for unpacking, normalization and rounding.
module fmas_add (
   input  logic                          clock,
   input  logic [7:0]                    en,
   input  logic                          dbl,
   input  logic                          check,
   input  fmas_pkg::unp_type             prod,
   input  logic [63:0]                   c,
   output logic [63:0]                   result,
   output logic                          not_finite
);
   import fmas_pkg::*;

   unp_type             uc;
   logic signed [13:0]  pe, ce, bexp, sexp;
   logic                c_big;
   logic signed [14:0]  ediff;
   spc_type             spc_in;
   spc_type             spc_ff [6:0];
   logic                bsgn1_in, bsgn1_ff;
   logic signed [13:0]  bexp1_in, bexp1_ff;
   logic [52:0]         bman1_in, bman1_ff;
   logic [52:0]         sman1_in, sman1_ff;
   logic [6:0]          d1_in, d1_ff;
   logic                sub1_in, sub1_ff;
   logic [127:0]        bf, bs;
   logic                stk;
   logic [127:0]        a2_in, a2_ff;
   logic [127:0]        b2_in, b2_ff;
   logic                sgn2_ff, sub2_ff;
   logic signed [13:0]  exp2_in, exp2_ff;
   logic [127:0]        sum;
   nrm_type             n3_in, n3_ff;
   nrm_type             n4_in, n4_ff;
   nrm_type             n5_in, n5_ff;
   rnd_type             r6_in, r6_ff;
   unp_type             r7_in, r7_ff;
   logic                sres;
   logic [12:0]         be;
   logic [63:0]         result_in, result_ff;
   logic                nf_in, nf_ff;

   // operand order and special cases
   always_comb begin
      uc = fp_unpack(c, dbl);
      pe = prod.zero ? ZERO_EXP : prod.exp;
      ce = uc.zero ? ZERO_EXP : uc.exp;
      c_big = (ce > pe) || ((ce == pe) && (uc.man > prod.man));
      bexp = c_big ? ce : pe;
      sexp = c_big ? pe : ce;
      bsgn1_in = c_big ? uc.sgn : prod.sgn;
      bexp1_in = bexp;
      bman1_in = c_big ? uc.man : prod.man;
      sman1_in = c_big ? prod.man : uc.man;
      ediff = $signed({bexp[13], bexp}) - $signed({sexp[13], sexp});
      d1_in = (ediff > 15'sd127) ? 7'd127 : ediff[6:0];
      sub1_in = prod.sgn ^ uc.sgn;
      spc_in.nan = prod.nan | uc.nan | (prod.inf & uc.inf & (prod.sgn ^ uc.sgn));
      spc_in.inf = prod.inf | uc.inf;
      spc_in.sgn = prod.inf ? prod.sgn : uc.sgn;
   end

   // alignment with sticky jam, then add or subtract
   always_comb begin
      a2_in = {1'b0, bman1_ff, 74'b0};
      bf = {1'b0, sman1_ff, 74'b0};
      bs = bf >> d1_ff;
      stk = |(bf & ~({128{1'b1}} << d1_ff));
      b2_in = {bs[127:1], bs[0] | stk};
      exp2_in = bexp1_ff + 14'sd1;
      sum = sub2_ff ? (a2_ff - b2_ff) : (a2_ff + b2_ff);
      n3_in.sgn = (sum == 128'd0) ? (sgn2_ff & ~sub2_ff) : sgn2_ff;
      n3_in.exp = exp2_ff;
      n3_in.frac = sum;
      n4_in = norm_hi(n3_ff);
      n5_in = norm_lo(n4_ff);
      r6_in = rnd_prep(n5_ff, dbl);
      r7_in = rnd_final(r6_ff, dbl);
   end

   // packing
   always_comb begin
      sres = spc_ff[6].inf ? spc_ff[6].sgn : r7_ff.sgn;
      if (r7_ff.man[52]) begin
         be = 13'(r7_ff.exp + (dbl ? DBL_BIAS : SGL_BIAS));
      end else begin
         be = 13'd0;
      end
      if (spc_ff[6].nan) begin
         result_in = dbl ? DBL_QNAN : SGL_QNAN;
      end else if (spc_ff[6].inf || r7_ff.inf) begin
         result_in = dbl ? {sres, 11'h7FF, 52'b0} : {32'b0, sres, 8'hFF, 23'b0};
      end else if (dbl) begin
         result_in = {r7_ff.sgn, be[10:0], r7_ff.man[51:0]};
      end else begin
         result_in = {32'b0, r7_ff.sgn, be[7:0], r7_ff.man[51:29]};
      end
      nf_in = check & (spc_ff[6].nan | spc_ff[6].inf | r7_ff.inf);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         bsgn1_ff <= bsgn1_in;
         bexp1_ff <= bexp1_in;
         bman1_ff <= bman1_in;
         sman1_ff <= sman1_in;
         d1_ff <= d1_in;
         sub1_ff <= sub1_in;
         spc_ff[0] <= spc_in;
      end
      if (en[1]) begin
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         sgn2_ff <= bsgn1_ff;
         exp2_ff <= exp2_in;
         sub2_ff <= sub1_ff;
         spc_ff[1] <= spc_ff[0];
      end
      if (en[2]) begin
         n3_ff <= n3_in;
         spc_ff[2] <= spc_ff[1];
      end
      if (en[3]) begin
         n4_ff <= n4_in;
         spc_ff[3] <= spc_ff[2];
      end
      if (en[4]) begin
         n5_ff <= n5_in;
         spc_ff[4] <= spc_ff[3];
      end
      if (en[5]) begin
         r6_ff <= r6_in;
         spc_ff[5] <= spc_ff[4];
      end
      if (en[6]) begin
         r7_ff <= r7_in;
         spc_ff[6] <= spc_ff[5];
      end
      if (en[7]) begin
         result_ff <= result_in;
         nf_ff <= nf_in;
      end
   end

   assign result = result_ff;
   assign not_finite = nf_ff;

endmodule

// File: rtl/float_multiply_add_stream.sv
// Streaming a*b+c over IEEE 754 single or double values, product and sum each
// rounded to nearest even. Every word passes a 14-stage pipeline (6 stages of
// multiply and round, 8 of add, round and pack), and one word is taken per
// cycle unless a full pipeline is stalled at the output. A stall holds only
// the stages that are full: empty stages keep filling. The user must write
// registers over the csr port only while the pipeline is empty; the block
// itself does not enforce it. Depends on fmas_pkg, fmas_mul and fmas_add.
module float_multiply_add_stream (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [191:0]  req_tdata,   // operand_a, operand_b, operand_c
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // result_value
   output logic          rsp_tuser,   // not_finite
   output logic          rsp_tlast,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [5:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import fmas_pkg::*;

   localparam logic [2:0] REG_PRECISION = 3'd0;
   localparam logic [2:0] REG_CHECK     = 3'd1;
   localparam logic [2:0] REG_USE_MUL   = 3'd2;
   localparam logic [2:0] REG_USE_ADD   = 3'd3;
   localparam logic [2:0] REG_FIX_MUL   = 3'd4;
   localparam logic [2:0] REG_FIX_ADD   = 3'd5;

   logic                   precision_ff, check_ff, use_mul_ff, use_add_ff;
   logic [63:0]            fix_mul_ff, fix_add_ff;
   logic                   csr_wr;
   logic [2:0]             csr_idx;
   logic [NUM_STAGES-1:0]  en;
   logic [NUM_STAGES-1:0]  v_in, v_ff;
   logic [NUM_STAGES-1:0]  last_ff;
   logic [63:0]            c_ff [MUL_STAGES-1:0];
   logic [63:0]            b_sel, c_sel;
   unp_type                prod;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= 1'b1;
         check_ff <= 1'b1;
         use_mul_ff <= 1'b0;
         use_add_ff <= 1'b0;
         fix_mul_ff <= 64'd0;
         fix_add_ff <= 64'd0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PRECISION: precision_ff <= csr_pwdata[0];
            REG_CHECK:     check_ff <= csr_pwdata[0];
            REG_USE_MUL:   use_mul_ff <= csr_pwdata[0];
            REG_USE_ADD:   use_add_ff <= csr_pwdata[0];
            REG_FIX_MUL:   fix_mul_ff <= csr_pwdata;
            REG_FIX_ADD:   fix_add_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PRECISION: csr_prdata = {63'd0, precision_ff};
         REG_CHECK:     csr_prdata = {63'd0, check_ff};
         REG_USE_MUL:   csr_prdata = {63'd0, use_mul_ff};
         REG_USE_ADD:   csr_prdata = {63'd0, use_add_ff};
         REG_FIX_MUL:   csr_prdata = fix_mul_ff;
         REG_FIX_ADD:   csr_prdata = fix_add_ff;
         default:       csr_prdata = 64'd0;
      endcase
   end

   // per-stage advance: a stage moves when empty or when the next one moves
   assign en[NUM_STAGES-1] = ~v_ff[NUM_STAGES-1] | rsp_tready;
   genvar k;
   generate
      for (k = 0; k < NUM_STAGES - 1; k++) begin : g_en
         assign en[k] = ~v_ff[k] | en[k+1];
      end
      for (k = 0; k < NUM_STAGES; k++) begin : g_valid
         if (k == 0) begin : g_first
            assign v_in[k] = en[k] ? req_tvalid : v_ff[k];
         end else begin : g_rest
            assign v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign b_sel = use_mul_ff ? fix_mul_ff : req_tdata[127:64];
   assign c_sel = use_add_ff ? fix_add_ff : req_tdata[191:128];

   // addend and last flag ride alongside the arithmetic
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            last_ff[i] <= (i == 0) ? req_tlast : last_ff[(i == 0) ? 0 : i - 1];
         end
      end
      for (int i = 0; i < MUL_STAGES; i++) begin
         if (en[i]) begin
            c_ff[i] <= (i == 0) ? c_sel : c_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   fmas_mul u_mul (
      .clock (clock),
      .en    (en[MUL_STAGES-1:0]),
      .dbl   (precision_ff),
      .a     (req_tdata[63:0]),
      .b     (b_sel),
      .prod  (prod)
   );

   fmas_add u_add (
      .clock      (clock),
      .en         (en[NUM_STAGES-1:MUL_STAGES]),
      .dbl        (precision_ff),
      .check      (check_ff),
      .prod       (prod),
      .c          (c_ff[MUL_STAGES-1]),
      .result     (rsp_tdata),
      .not_finite (rsp_tuser)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NUM_STAGES-1];
   assign rsp_tlast = last_ff[NUM_STAGES-1];

   a_flag_needs_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> check_ff)
      else $error("not_finite set while checking is off");

   a_single_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !precision_ff |-> rsp_tdata[63:32] == 32'd0)
      else $error("single result with nonzero upper word");

   a_canonical_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && precision_ff && rsp_tdata[62:52] == 11'h7FF
         && rsp_tdata[51:0] != 52'd0 |-> rsp_tdata == DBL_QNAN)
      else $error("double nan not canonical");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready && (&v_ff))
      else $error("input stalled while pipeline has room");

endmodule

// File: dv/testbench.sv
// testbench: self-checking bench for float_multiply_add_stream, a directed table then
// random words in phases of register settings and idling, checked against a local predictor
// depends on fmas_pkg and the float_multiply_add_stream rtl
`timescale 1ns / 1ps

module testbench;
   import fmas_pkg::*;

   localparam logic [5:0] REG_PRECISION  = 6'd0;
   localparam logic [5:0] REG_CHECK      = 6'd1;
   localparam logic [5:0] REG_USE_FIXED_B = 6'd2;
   localparam logic [5:0] REG_USE_FIXED_C = 6'd3;
   localparam logic [5:0] REG_FIXED_B    = 6'd4;
   localparam logic [5:0] REG_FIXED_C    = 6'd5;
   localparam int PHASE_WORDS = 205;

   typedef struct {
      logic [63:0] value;
      logic        flag;
      logic        last;
   } mad_result_type;

   typedef struct {
      bit          dbl;
      logic [63:0] a, b, c;
      bit          last;
      bit          known;
      logic [63:0] value;
      bit          flag;
   } vector_type;

   typedef struct {
      bit          dbl, check, use_b, use_c;
      logic [63:0] fixed_b, fixed_c;
      int          idle_pct, stall_pct;
   } phase_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [191:0]  req_tdata = '0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [5:0]    csr_paddr = '0;
   logic [63:0]   csr_pwdata = '0;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   bit          cfg_dbl = 1'b1;
   bit          cfg_check = 1'b1;
   bit          cfg_use_b = 1'b0;
   bit          cfg_use_c = 1'b0;
   logic [63:0] cfg_fixed_b = '0;
   logic [63:0] cfg_fixed_c = '0;

   mad_result_type pending_results[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int words_sent = 0;
   int results_seen = 0;
   int flagged_seen = 0;

   float_multiply_add_stream i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic real single_to_real(input logic [31:0] s);
      logic [10:0] ex;
      real         mag;
      if (s[30:23] == 8'hFF) begin
         return $bitstoreal({s[31], 11'h7FF, (s[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'd0});
      end
      if (s[30:23] == 8'h00) begin
         // subnormal: frac * 2^-149, exact in double
         mag = real'(s[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
         return s[31] ? -mag : mag;
      end
      ex = {3'b000, s[30:23]} + 11'd896;
      return $bitstoreal({s[31], ex, s[22:0], 29'd0});
   endfunction

   // round a double to single, nearest even
   function automatic logic [31:0] round_to_single(input logic [63:0] d);
      logic        sgn;
      logic [63:0] m, kept, rest, half;
      logic [7:0]  ef;
      int          ue, sh;
      sgn = d[63];
      if (d[62:52] == 11'h7FF) begin
         return (d[51:0] != 0) ? SGL_QNAN[31:0] : {sgn, 8'hFF, 23'd0};
      end
      if (d[62:52] == 11'd0) return {sgn, 31'd0};
      ue = int'(d[62:52]) - 1023;
      m = {11'd0, 1'b1, d[51:0]};
      sh = 29;
      if (ue < -126) sh = 29 + (-126 - ue);
      if (sh > 60) sh = 60;
      kept = m >> sh;
      rest = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
      if (ue < -126) return {sgn, kept[30:0]};
      if (kept[24]) begin
         kept = kept >> 1;
         ue = ue + 1;
      end
      if (ue > 127) return {sgn, 8'hFF, 23'd0};
      ef = 8'(ue + 127);
      return {sgn, ef, kept[22:0]};
   endfunction

   function automatic mad_result_type predict_mad(input logic [63:0] a, b_in, c_in,
                                                  input logic last);
      mad_result_type res;
      logic [63:0] b, c, bits;
      logic [31:0] prod32, sum32;
      real         x, y, z, p;
      b = cfg_use_b ? cfg_fixed_b : b_in;
      c = cfg_use_c ? cfg_fixed_c : c_in;
      if (cfg_dbl) begin
         x = $bitstoreal(a);
         y = $bitstoreal(b);
         z = $bitstoreal(c);
         p = x * y;
         bits = $realtobits(p + z);
         if (bits[62:52] == 11'h7FF && bits[51:0] != 0) bits = DBL_QNAN;
         res.flag = cfg_check && (bits[62:52] == 11'h7FF);
      end else begin
         // single product is exact in double, sum rounds safely twice
         p = single_to_real(a[31:0]) * single_to_real(b[31:0]);
         prod32 = round_to_single($realtobits(p));
         p = single_to_real(prod32) + single_to_real(c[31:0]);
         sum32 = round_to_single($realtobits(p));
         bits = {32'd0, sum32};
         res.flag = cfg_check && (sum32[30:23] == 8'hFF);
      end
      res.value = bits;
      res.last = last;
      return res;
   endfunction

   function automatic logic [63:0] special_operand(input bit dbl, input int k);
      logic [63:0] v;
      case (k)
         0: v = dbl ? 64'h0 : 64'h0;
         1: v = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
         2: v = dbl ? 64'h7FF0_0000_0000_0000 : 64'h7F80_0000;
         3: v = dbl ? 64'hFFF0_0000_0000_0000 : 64'hFF80_0000;
         4: v = dbl ? 64'h7FF0_0000_0000_0001 : 64'h7F80_0001;
         5: v = dbl ? 64'h7FEF_FFFF_FFFF_FFFF : 64'h7F7F_FFFF;
         6: v = dbl ? 64'h0000_0000_0000_0001 : 64'h0000_0001;
         default: v = dbl ? 64'h3FF0_0000_0000_0000 : 64'h3F80_0000;
      endcase
      if (!dbl) v[63:32] = $urandom;
      return v;
   endfunction

   function automatic logic [63:0] random_operand(input bit dbl);
      logic [63:0] v;
      logic [10:0] e;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1: ;
         2: v = special_operand(dbl, $urandom_range(7));
         3: begin
            if (dbl) v[62:52] = 11'($urandom_range(1, 2046));
            else v[30:23] = 8'($urandom_range(1, 254));
         end
         default: begin
            e = 11'($urandom_range(0, 40));
            if (dbl) v[62:52] = 11'd1003 + e;
            else v[30:23] = 8'd107 + e[7:0];
         end
      endcase
      return v;
   endfunction

   task automatic csr_write(input logic [5:0] idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx[2:0], 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PRECISION:   cfg_dbl = value[0];
         REG_CHECK:       cfg_check = value[0];
         REG_USE_FIXED_B: cfg_use_b = value[0];
         REG_USE_FIXED_C: cfg_use_c = value[0];
         REG_FIXED_B:     cfg_fixed_b = value;
         REG_FIXED_C:     cfg_fixed_c = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
   endtask

   task automatic send_word(input logic [63:0] a, b, c, input logic last,
                            input mad_result_type expected);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(expected);
      words_sent++;
   endtask

   always @(posedge clock) begin
      mad_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) flagged_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: value %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value || rsp_tuser !== want.flag ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h nf %b last %b, got %h nf %b last %b",
                           want.value, want.flag, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   vector_type directed[] = '{
      '{1, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h0, 0, 1,
        64'h3FF0_0000_0000_0000, 0},
      '{1, 64'h4000_0000_0000_0000, 64'h4008_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1, 1,
        64'h401C_0000_0000_0000, 0},
      '{1, 64'h7FEF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 64'h0, 0, 1,
        64'h7FF0_0000_0000_0000, 1},
      '{1, 64'h7FF0_0000_0000_0000, 64'h0, 64'h0, 0, 1, 64'h7FF8_0000_0000_0000, 1},
      '{1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1,
        64'h7FF8_0000_0000_0000, 1},
      '{1, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000, 0, 1,
        64'h8000_0000_0000_0000, 0},
      '{1, 64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'h0, 0, 1, 64'h0, 0},
      '{1, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 0, 1,
        64'h0, 0},
      '{1, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1, 1,
        64'h7FF8_0000_0000_0000, 1},
      '{1, 64'h3FF5_5555_5555_5555, 64'h4008_0000_0000_0000, 64'h3BC8_0000_0000_0001, 0, 0,
        64'h0, 0},
      '{1, 64'h0010_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 0, 0,
        64'h0, 0},
      '{0, 64'hDEAD_BEEF_3F80_0000, 64'h1234_5678_4000_0000, 64'hFFFF_FFFF_3F80_0000, 0, 1,
        64'h4040_0000, 0},
      '{0, 64'h7F7F_FFFF, 64'h4000_0000, 64'h0, 1, 1, 64'h7F80_0000, 1},
      '{0, 64'h0000_0001, 64'h3F00_0000, 64'h0, 0, 1, 64'h0, 0},
      '{0, 64'h0000_0003, 64'h3F00_0000, 64'h0, 0, 1, 64'h2, 0},
      '{0, 64'h7F80_0001, 64'h3F80_0000, 64'h0, 0, 1, 64'h7FC0_0000, 1},
      '{0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1,
        64'h7FC0_0000, 1},
      '{0, 64'hBF80_0000, 64'hBF80_0000, 64'hBF80_0000, 0, 1, 64'h0, 0},
      '{0, 64'h3FAA_AAAB, 64'h4040_0000, 64'h3380_0001, 0, 0, 64'h0, 0},
      '{0, 64'h0080_0001, 64'h3F7F_FFFF, 64'h8000_0001, 1, 0, 64'h0, 0}
   };

   phase_type phases[8];

   initial begin
      mad_result_type want;
      logic [63:0] a, b, c;
      logic        last;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].dbl != cfg_dbl) begin
            req_tvalid <= 1'b0;
            wait_drained();
            csr_write(REG_PRECISION, {63'd0, directed[i].dbl});
         end
         want = predict_mad(directed[i].a, directed[i].b, directed[i].c, directed[i].last);
         if (directed[i].known) begin
            want.value = directed[i].value;
            want.flag = directed[i].flag;
         end
         send_word(directed[i].a, directed[i].b, directed[i].c, directed[i].last, want);
      end

      phases[0] = '{1, 1, 0, 0, 64'h0, 64'h0, 0, 0};
      phases[1] = '{0, 1, 0, 0, 64'h0, 64'h0, 46, 0};
      phases[2] = '{1, 0, 1, 0, {2'b00, 10'h3FF, $urandom, 20'($urandom)}, 64'h0, 0, 46};
      phases[3] = '{0, 1, 1, 1, {$urandom, 32'h3FC0_0000}, {$urandom, 32'hBF00_0000}, 38, 38};
      phases[4] = '{1, 1, 0, 1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0};
      phases[5] = '{0, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 46, 0};
      phases[6] = '{1, 1, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, 46};
      phases[7] = '{0, 1, 0, 0, 64'h0, 64'h0, 38, 38};

      foreach (phases[p]) begin
         req_tvalid <= 1'b0;
         wait_drained();
         csr_write(REG_PRECISION, {63'd0, phases[p].dbl});
         csr_write(REG_CHECK, {63'd0, phases[p].check});
         csr_write(REG_USE_FIXED_B, {63'd0, phases[p].use_b});
         csr_write(REG_USE_FIXED_C, {63'd0, phases[p].use_c});
         csr_write(REG_FIXED_B, phases[p].fixed_b);
         csr_write(REG_FIXED_C, phases[p].fixed_c);
         idle_pct = phases[p].idle_pct;
         stall_pct = phases[p].stall_pct;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 7 && n == PHASE_WORDS / 2) begin
               req_tvalid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            a = random_operand(cfg_dbl);
            b = random_operand(cfg_dbl);
            c = random_operand(cfg_dbl);
            // exact cancellation: a*1 - a
            if ($urandom_range(9) == 0) begin
               b = special_operand(cfg_dbl, 7);
               c = a;
               if (cfg_dbl) c[63] = ~c[63];
               else c[31] = ~c[31];
            end
            last = ($urandom_range(7) == 0);
            want = predict_mad(a, b, c, last);
            send_word(a, b, c, last, want);
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      $display("%0d words sent, %0d results checked, %0d flagged not finite",
               words_sent, results_seen, flagged_seen);
      $display("covered single and double precision, fixed operands and checking on and off");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
